/* rtl/bmse_pkg.sv */
// ----------------------------------------------------------------------------
// bmse_pkg
// Shared types, command codes and helpers for the byte matrix scramble engine.
// ----------------------------------------------------------------------------
package bmse_pkg;

  localparam int unsigned NumBytes    = 16;
  localparam int unsigned CmdQDepth   = 2;
  localparam int unsigned ResQDepth   = 2;

  typedef logic [7:0] byte_t;
  typedef byte_t [NumBytes-1:0] mat_t;

  typedef enum logic [4:0] {
    ActRotRowL   = 5'd0,
    ActRotRowR   = 5'd1,
    ActRotColU   = 5'd2,
    ActRotColD   = 5'd3,
    ActSwapRow   = 5'd4,
    ActSwapCol   = 5'd5,
    ActXorRow    = 5'd6,
    ActAddRow    = 5'd7,
    ActXorCol    = 5'd8,
    ActAddCol    = 5'd9,
    ActWeaveRow  = 5'd10,
    ActWeaveCol  = 5'd11,
    ActRotMatR   = 5'd12,
    ActRotMatL   = 5'd13,
    ActFlipH     = 5'd14,
    ActFlipV     = 5'd15,
    ActTranspose = 5'd16,
    ActAntiDiag  = 5'd17,
    ActRing      = 5'd18,
    ActCross     = 5'd19,
    ActLoadHalf  = 5'd20,
    ActXorHalf   = 5'd21,
    ActAddHalf   = 5'd22,
    ActClear     = 5'd23,
    ActNop       = 5'd24
  } act_e;

  // decoded command passed from front to back
  typedef struct packed {
    act_e        act;
    logic        is_col;
    logic [1:0]  ia;
    logic [1:0]  ib;
    logic [1:0]  amt;
    logic [3:0]  ring_s;
    logic        hi_half;
    logic [63:0] data;
  } cmd_t;

  localparam logic [3:0] RingOrder [12] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12, 4'd8, 4'd4};
  localparam logic [3:0] MapRotR [16] = '{
    4'd12, 4'd8, 4'd4, 4'd0, 4'd13, 4'd9, 4'd5, 4'd1,
    4'd14, 4'd10, 4'd6, 4'd2, 4'd15, 4'd11, 4'd7, 4'd3};
  localparam logic [3:0] MapRotL [16] = '{
    4'd3, 4'd7, 4'd11, 4'd15, 4'd2, 4'd6, 4'd10, 4'd14,
    4'd1, 4'd5, 4'd9, 4'd13, 4'd0, 4'd4, 4'd8, 4'd12};
  localparam logic [3:0] MapAnti [16] = '{
    4'd15, 4'd11, 4'd7, 4'd3, 4'd14, 4'd10, 4'd6, 4'd2,
    4'd13, 4'd9, 4'd5, 4'd1, 4'd12, 4'd8, 4'd4, 4'd0};
  localparam logic [3:0] CrossPos [4] = '{4'd1, 4'd6, 4'd9, 4'd4};

  // cell index from line, position and orientation
  function automatic logic [3:0] cell_idx(logic [1:0] line, logic [1:0] k, logic is_col);
    cell_idx = is_col ? {k, line} : {line, k};
  endfunction

endpackage

/* rtl/bmse_front.sv */
// ----------------------------------------------------------------------------
// bmse_front
// Accepts items, classifies the action and masks arguments into a command.
// ----------------------------------------------------------------------------
module bmse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [4:0]      action_i,
  input  logic [7:0]      first_arg_i,
  input  logic [7:0]      second_arg_i,
  input  logic [63:0]     data_half_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output bmse_pkg::cmd_t  cmd_o
);

  localparam int unsigned AW = $clog2(bmse_pkg::CmdQDepth);

  bmse_pkg::cmd_t         dec;
  bmse_pkg::cmd_t         mem_q [bmse_pkg::CmdQDepth];
  logic [AW-1:0]          wp_q, rp_q;
  logic [AW:0]            cnt_q;
  logic                   wr, rd;
  logic [8:0]             ring_a;

  // classify the action
  always_comb begin
    dec         = '0;
    dec.ia      = first_arg_i[1:0];
    dec.ib      = second_arg_i[1:0];
    dec.hi_half = first_arg_i[0];
    dec.data    = data_half_i;
    dec.amt     = first_arg_i[1:0];
    ring_a      = {1'b0, first_arg_i};
    ring_a      = (ring_a >= 9'd192) ? ring_a - 9'd192 : ring_a;
    ring_a      = (ring_a >= 9'd96)  ? ring_a - 9'd96  : ring_a;
    ring_a      = (ring_a >= 9'd48)  ? ring_a - 9'd48  : ring_a;
    ring_a      = (ring_a >= 9'd24)  ? ring_a - 9'd24  : ring_a;
    ring_a      = (ring_a >= 9'd12)  ? ring_a - 9'd12  : ring_a;
    dec.ring_s  = ring_a[3:0];
    dec.act     = bmse_pkg::ActNop;
    if (action_i <= 5'(bmse_pkg::ActClear)) dec.act = bmse_pkg::act_e'(action_i);
    case (dec.act)
      bmse_pkg::ActRotColU, bmse_pkg::ActRotColD, bmse_pkg::ActSwapCol,
      bmse_pkg::ActXorCol, bmse_pkg::ActAddCol, bmse_pkg::ActWeaveCol: dec.is_col = 1'b1;
      default:                                                         dec.is_col = 1'b0;
    endcase
    // equal line pair: turn folds into rotations, drop swaps and weaves
    if (dec.ia == dec.ib) begin
      case (dec.act)
        bmse_pkg::ActXorRow: begin dec.act = bmse_pkg::ActRotRowL; dec.ib = 2'd1; end
        bmse_pkg::ActAddRow: begin dec.act = bmse_pkg::ActRotRowL; dec.ib = 2'd3; end
        bmse_pkg::ActXorCol: begin dec.act = bmse_pkg::ActRotColU; dec.ib = 2'd1; end
        bmse_pkg::ActAddCol: begin dec.act = bmse_pkg::ActRotColU; dec.ib = 2'd3; end
        bmse_pkg::ActSwapRow, bmse_pkg::ActSwapCol,
        bmse_pkg::ActWeaveRow, bmse_pkg::ActWeaveCol: dec.act = bmse_pkg::ActNop;
        default: ;
      endcase
    end
    // right and down become left and up by the complement
    if (dec.act == bmse_pkg::ActRotRowR) begin
      dec.act = bmse_pkg::ActRotRowL; dec.ib = 2'd0 - dec.ib;
    end else if (dec.act == bmse_pkg::ActRotColD) begin
      dec.act = bmse_pkg::ActRotColU; dec.ib = 2'd0 - dec.ib;
    end
  end

  assign full        = (cnt_q == (AW+1)'(bmse_pkg::CmdQDepth));
  assign wr          = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign rd          = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rp_q];

  // command queue storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= dec;
  end

  // command queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

/* rtl/bmse_back.sv */
// ----------------------------------------------------------------------------
// bmse_back
// Holds the matrix, applies one command a cycle while the result queue has room, queues the snapshots.
// ----------------------------------------------------------------------------
module bmse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  bmse_pkg::cmd_t  cmd_i,
  output logic            empty,
  input  logic            pop,
  output logic [63:0]     matrix_low_o,
  output logic [63:0]     matrix_high_o
);

  localparam int unsigned AW = $clog2(bmse_pkg::ResQDepth);

  bmse_pkg::mat_t mat_q, mat_d, cr_m;
  bmse_pkg::mat_t res_q [bmse_pkg::ResQDepth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;
  logic           go, rd;
  logic [7:0]     x, sum;
  logic [7:0]     cr [4];
  logic [3:0]     pa, pb;
  logic [4:0]     rj;

  assign cmd_ready_o = (cnt_q != (AW+1)'(bmse_pkg::ResQDepth));
  assign go          = cmd_valid_i && cmd_ready_o;
  assign empty       = (cnt_q == '0);
  assign rd          = pop && !empty;
  assign matrix_low_o  = {res_q[rp_q][7], res_q[rp_q][6], res_q[rp_q][5], res_q[rp_q][4],
                          res_q[rp_q][3], res_q[rp_q][2], res_q[rp_q][1], res_q[rp_q][0]};
  assign matrix_high_o = {res_q[rp_q][15], res_q[rp_q][14], res_q[rp_q][13], res_q[rp_q][12],
                          res_q[rp_q][11], res_q[rp_q][10], res_q[rp_q][9], res_q[rp_q][8]};

  // next matrix
  always_comb begin
    mat_d = mat_q;
    cr_m  = mat_q;
    x     = '0;
    sum   = '0;
    for (int i = 0; i < 4; i++) cr[i] = '0;
    pa    = '0;
    pb    = '0;
    rj    = '0;
    case (cmd_i.act)
      bmse_pkg::ActRotRowL, bmse_pkg::ActRotColU: begin
        for (int k = 0; k < 4; k++)
          mat_d[bmse_pkg::cell_idx(cmd_i.ia, 2'(k), cmd_i.is_col)] =
            mat_q[bmse_pkg::cell_idx(cmd_i.ia, 2'(k) + cmd_i.ib, cmd_i.is_col)];
      end
      bmse_pkg::ActSwapRow, bmse_pkg::ActSwapCol,
      bmse_pkg::ActWeaveRow, bmse_pkg::ActWeaveCol: begin
        for (int k = 0; k < 4; k++) begin
          pa = bmse_pkg::cell_idx(cmd_i.ia, 2'(k), cmd_i.is_col);
          pb = bmse_pkg::cell_idx(cmd_i.ib, 2'(k), cmd_i.is_col);
          if ((cmd_i.act == bmse_pkg::ActSwapRow) || (cmd_i.act == bmse_pkg::ActSwapCol)
              || (k % 2 == 1)) begin
            mat_d[pa] = mat_q[pb];
            mat_d[pb] = mat_q[pa];
          end
        end
      end
      bmse_pkg::ActXorRow, bmse_pkg::ActXorCol,
      bmse_pkg::ActAddRow, bmse_pkg::ActAddCol: begin
        for (int k = 0; k < 4; k++) begin
          pa = bmse_pkg::cell_idx(cmd_i.ia, 2'(k), cmd_i.is_col);
          pb = bmse_pkg::cell_idx(cmd_i.ib, 2'(k), cmd_i.is_col);
          if ((cmd_i.act == bmse_pkg::ActXorRow) || (cmd_i.act == bmse_pkg::ActXorCol))
            mat_d[pa] = mat_q[pa] ^ mat_q[pb];
          else
            mat_d[pa] = mat_q[pa] + mat_q[pb];
        end
      end
      bmse_pkg::ActRotMatR:
        for (int i = 0; i < 16; i++) mat_d[i] = mat_q[bmse_pkg::MapRotR[i]];
      bmse_pkg::ActRotMatL:
        for (int i = 0; i < 16; i++) mat_d[i] = mat_q[bmse_pkg::MapRotL[i]];
      bmse_pkg::ActAntiDiag:
        for (int i = 0; i < 16; i++) mat_d[i] = mat_q[bmse_pkg::MapAnti[i]];
      bmse_pkg::ActFlipH:
        for (int i = 0; i < 16; i++) mat_d[i] = mat_q[{i[3:2], ~i[1:0]}];
      bmse_pkg::ActFlipV:
        for (int i = 0; i < 16; i++) mat_d[i] = mat_q[{~i[3:2], i[1:0]}];
      bmse_pkg::ActTranspose:
        for (int i = 0; i < 16; i++) mat_d[i] = mat_q[{i[1:0], i[3:2]}];
      bmse_pkg::ActRing: begin
        // ring slot that lands on slot i: one compare and subtract wraps it
        for (int i = 0; i < 12; i++) begin
          rj = 5'(i) + 5'd12 - {1'b0, cmd_i.ring_s};
          if (rj >= 5'd12) rj = rj - 5'd12;
          mat_d[bmse_pkg::RingOrder[i]] = mat_q[bmse_pkg::RingOrder[rj[3:0]]];
        end
      end
      bmse_pkg::ActCross: begin
        for (int i = 0; i < 4; i++)
          cr[i] = mat_q[bmse_pkg::CrossPos[i]] + mat_q[i*3];
        for (int i = 0; i < 4; i++)
          cr_m[bmse_pkg::CrossPos[i]] = cr[2'(i) + cmd_i.amt];
        for (int i = 0; i < 16; i++) x = x ^ cr_m[i];
        cr_m[5] = cr_m[5] ^ x;
        for (int i = 0; i < 16; i++) sum = sum + cr_m[i];
        cr_m[10] = cr_m[10] + sum;
        mat_d = cr_m;
      end
      bmse_pkg::ActLoadHalf, bmse_pkg::ActXorHalf, bmse_pkg::ActAddHalf: begin
        for (int k = 0; k < 8; k++) begin
          pa = {cmd_i.hi_half, 3'(k)};
          if (cmd_i.act == bmse_pkg::ActLoadHalf) mat_d[pa] = cmd_i.data[8*k +: 8];
          else if (cmd_i.act == bmse_pkg::ActXorHalf)
            mat_d[pa] = mat_q[pa] ^ cmd_i.data[8*k +: 8];
          else mat_d[pa] = mat_q[pa] + cmd_i.data[8*k +: 8];
        end
      end
      bmse_pkg::ActClear: mat_d = '0;
      default: ;
    endcase
  end

  // matrix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mat_q <= '0;
    else if (go) mat_q <= mat_d;
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (go) res_q[wp_q] <= mat_d;
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (go) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(go) - (AW+1)'(rd);
    end
  end

endmodule

/* rtl/byte_matrix_scramble_engine.sv */
// ----------------------------------------------------------------------------
// byte_matrix_scramble_engine
// 4x4 byte matrix mixer: one command per item, full matrix returned per item.
// ----------------------------------------------------------------------------
// channel   | handshake     | payload
// input     | push / full   | action_i, first_arg_i, second_arg_i, data_half_i
// result    | empty / pop   | matrix_low_o, matrix_high_o
//
// one item per cycle sustained while results are popped; empty goes low once the item has
// passed the command queue and then the matrix update into the result queue.
// reset clears the matrix to zero and empties both queues.
// a stalled result side fills the result queue, then the command queue, then full.
module byte_matrix_scramble_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  action_i,
  input  logic [7:0]  first_arg_i,
  input  logic [7:0]  second_arg_i,
  input  logic [63:0] data_half_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] matrix_low_o,
  output logic [63:0] matrix_high_o
);

  bmse_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;

  // front: accept and classify
  bmse_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .action_i, .first_arg_i, .second_arg_i, .data_half_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // back: matrix update and results
  bmse_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .empty, .pop, .matrix_low_o, .matrix_high_o
  );

endmodule
